@@ sv/gcd_pkg.sv @@
// shared constants, types and tables for the great-circle distance pipeline
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 20;
  localparam int CORDIC_STAGES   = 24;
  localparam int SQRT_STEPS      = 31;
  localparam int G2R_LAT         = 7;

  localparam logic [15:0] RADIUS_RESET = 16'd6371;
  localparam logic [31:0] PI_Q30       = 32'hC90FDAA2;
  localparam logic [32:0] TWO_PI_Q30   = 33'h1921FB544;
  localparam logic [30:0] HALF_PI_Q30  = 31'h6487ED51;
  localparam logic [31:0] GAIN_Q30     = 32'h26DD3B6A;
  localparam logic [30:0] ONE_Q30      = 31'h40000000;
  // pi*2^32 = 180*DIV_Q + 104, and 104/180 = 26/45
  localparam logic [26:0] DIV_Q        = 27'd74961320;
  localparam logic [30:0] RECIP_45     = 31'd1527099484;
  localparam logic [25:0] DIST_MAX     = 26'h3FFFFFF;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic {CORD_ROT, CORD_VEC} cord_mode_t;

  typedef logic signed [33:0] cw_t;

  typedef struct packed {
    logic valid;
    logic tag;
    cw_t  x;
    cw_t  y;
    cw_t  z;
  } cord_t;

  typedef struct packed {
    logic        valid;
    logic [60:0] n;
    logic [61:0] r;
  } sqrt_t;

  // floor(26*b/45) for b below 45
  function automatic logic [4:0] frac_26_45(input logic [5:0] b);
    logic [4:0] f;
    unique case (b)
      6'd0, 6'd1:           f = 5'd0;
      6'd2, 6'd3:           f = 5'd1;
      6'd4, 6'd5:           f = 5'd2;
      6'd6:                 f = 5'd3;
      6'd7, 6'd8:           f = 5'd4;
      6'd9, 6'd10:          f = 5'd5;
      6'd11, 6'd12:         f = 5'd6;
      6'd13:                f = 5'd7;
      6'd14, 6'd15:         f = 5'd8;
      6'd16, 6'd17:         f = 5'd9;
      6'd18, 6'd19:         f = 5'd10;
      6'd20:                f = 5'd11;
      6'd21, 6'd22:         f = 5'd12;
      6'd23, 6'd24:         f = 5'd13;
      6'd25:                f = 5'd14;
      6'd26, 6'd27:         f = 5'd15;
      6'd28, 6'd29:         f = 5'd16;
      6'd30, 6'd31:         f = 5'd17;
      6'd32:                f = 5'd18;
      6'd33, 6'd34:         f = 5'd19;
      6'd35, 6'd36:         f = 5'd20;
      6'd37, 6'd38:         f = 5'd21;
      6'd39:                f = 5'd22;
      6'd40, 6'd41:         f = 5'd23;
      6'd42, 6'd43:         f = 5'd24;
      6'd44:                f = 5'd25;
      default:              f = 5'd0;
    endcase
    return f;
  endfunction

endpackage

@@ sv/gcd_rad.sv @@
// degrees to radians, range reduction and quadrant fold, pipelined
module gcd_rad (
  input  logic              clk,
  input  logic              halve,
  input  logic signed [29:0] deg,
  output gcd_pkg::cw_t      z,
  output logic              flip
);
  import gcd_pkg::*;

  localparam logic signed [36:0] PI_S   = 37'(PI_Q30);
  localparam logic signed [36:0] HALF_S = 37'(HALF_PI_Q30);

  logic        neg1, neg2, neg3, neg4, neg5;
  logic [29:0] m1, m2;
  logic [60:0] pc2;
  logic [24:0] a3;
  logic [5:0]  b3;
  logic [56:0] pq3, p4;
  logic [34:0] r5;
  logic signed [36:0] a6, w;
  logic [29:0] q45;
  logic [5:0]  sh;

  always_comb begin
    q45 = 30'(pc2[60:36]) * 30'd45;
    sh  = 6'(ANGLE_FRAC_BITS + 2) + {5'b0, halve};
    w   = (r5 > 35'(PI_Q30)) ? 37'(r5) - 37'(TWO_PI_Q30) : 37'(r5);
  end

  always_ff @(posedge clk) begin
    neg1 <= deg[29];
    m1   <= deg[29] ? 30'(-deg) : 30'(deg);
    // quotient by 45 through the reciprocal, exact below 2^30
    pc2  <= m1 * RECIP_45;
    m2   <= m1;
    neg2 <= neg1;
    a3   <= pc2[60:36];
    b3   <= 6'(m2 - q45);
    pq3  <= m2 * DIV_Q;
    neg3 <= neg2;
    p4   <= pq3 + 57'(a3) * 57'd26 + 57'(frac_26_45(b3));
    neg4 <= neg3;
    r5   <= 35'((p4 + (57'd1 << (sh - 6'd1))) >> sh);
    neg5 <= neg4;
    a6   <= neg5 ? -w : w;
    if (a6 > HALF_S) begin
      z    <= cw_t'(a6 - PI_S);
      flip <= 1'b1;
    end else if (a6 < -HALF_S) begin
      z    <= cw_t'(a6 + PI_S);
      flip <= 1'b1;
    end else begin
      z    <= cw_t'(a6);
      flip <= 1'b0;
    end
  end

endmodule

@@ sv/gcd_cordic_cell.sv @@
// one cordic micro-rotation, rotation or vectoring mode
module gcd_cordic_cell (
  input  logic                clk,
  input  logic                rst,
  input  gcd_pkg::cord_mode_t mode,
  input  logic [4:0]          idx,
  input  gcd_pkg::cord_t      din,
  output gcd_pkg::cord_t      dout
);
  import gcd_pkg::*;

  cw_t  dx, dy, at;
  logic dir;

  always_comb begin
    dx  = din.y >>> idx;
    dy  = din.x >>> idx;
    at  = cw_t'({2'b00, ATAN_Q30[idx]});
    dir = (mode == CORD_VEC) ? (din.y <= 0) : (din.z >= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.tag <= din.tag;
    if (dir) begin
      dout.x <= din.x - dx;
      dout.y <= din.y + dy;
      dout.z <= din.z - at;
    end else begin
      dout.x <= din.x + dx;
      dout.y <= din.y - dy;
      dout.z <= din.z + at;
    end
  end

endmodule

@@ sv/gcd_sqrt_cell.sv @@
// one step of the digit-by-digit integer square root
module gcd_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic [4:0]     idx,
  input  gcd_pkg::sqrt_t din,
  output gcd_pkg::sqrt_t dout
);
  import gcd_pkg::*;

  logic [6:0]  pos;
  logic [61:0] bit_w, trial;
  logic        take;

  always_comb begin
    pos   = 7'd60 - {1'b0, idx, 1'b0};
    bit_w = 62'd1 << pos;
    trial = din.r + bit_w;
    take  = {1'b0, din.n} >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    if (take) begin
      dout.n <= din.n - trial[60:0];
      dout.r <= (din.r >> 1) + bit_w;
    end else begin
      dout.n <= din.n;
      dout.r <= din.r >> 1;
    end
  end

endmodule

@@ sv/great_circle_distance.sv @@
// haversine great-circle distance, fully pipelined top level
//
//   channel   | ports                              | transfer
//   ----------+------------------------------------+---------------------------
//   points    | lat_a lon_a lat_b lon_b            | start high, busy low
//   distance  | distance                           | done high for one cycle
//   radius    | cfg_wdata                          | cfg_we high
//
// one pair enters per cycle while busy is low; after input capture it passes the
// chain of cells: 7 conversion stages, 24 rotation cordic cells, 4 multiply
// stages, 31 square-root cells and 24 vectoring cordic cells, then the output registers.
// synchronous reset clears all valid bits and restores the 6371 km radius;
// busy is high while reset is held and in the cycle after it. the receiver cannot stall.
module great_circle_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [27:0] lat_a,
  input  logic signed [28:0] lon_a,
  input  logic signed [27:0] lat_b,
  input  logic signed [28:0] lon_b,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               done,
  output logic [25:0]        distance
);
  import gcd_pkg::*;

  localparam int CE = CORDIC_STAGES;
  localparam int SE = SQRT_STEPS;

  function automatic logic signed [31:0] sel_q30(input cw_t v, input logic f);
    logic signed [31:0] c;
    if (v > cw_t'(ONE_Q30)) c = 32'(ONE_Q30);
    else if (v < -cw_t'(ONE_Q30)) c = -32'(ONE_Q30);
    else c = 32'(v);
    return f ? -c : c;
  endfunction

  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'((p + 64'sd536870912) >>> 30);
  endfunction

  logic [15:0] radius;
  logic        v_in;
  logic signed [29:0] rdeg [4];
  cw_t         rz [4];
  logic        rf [4];
  logic [G2R_LAT-1:0] v_rad;
  cord_t       rot [4][CE+1];
  logic signed [31:0] s_lat, s_lon, c_a, c_b, sl2, so2, cab, t2, sl2_d;
  logic signed [32:0] sum;
  logic        v_p1, v_m1, v_m2, v_m3, v_a1, v_d1;
  logic [30:0] a3;
  sqrt_t       sq_c [SE+1];
  sqrt_t       cq_c [SE+1];
  cord_t       vec [CE+1];
  logic [32:0] ang;
  logic [48:0] prod;
  logic [27:0] rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b1;
      radius <= RADIUS_RESET;
      v_in   <= 1'b0;
      v_rad  <= '0;
      v_p1   <= 1'b0;
      v_m1   <= 1'b0;
      v_m2   <= 1'b0;
      v_m3   <= 1'b0;
      v_a1   <= 1'b0;
      v_d1   <= 1'b0;
      done   <= 1'b0;
    end else begin
      busy  <= 1'b0;
      if (cfg_we) begin
        radius <= cfg_wdata;
      end
      v_in  <= start && !busy;
      v_rad <= {v_rad[G2R_LAT-2:0], v_in};
      v_p1  <= rot[0][CE].valid & rot[1][CE].valid & rot[2][CE].valid & rot[3][CE].valid;
      v_m1  <= v_p1;
      v_m2  <= v_m1;
      v_m3  <= v_m2;
      v_a1  <= vec[CE].valid;
      v_d1  <= v_a1;
      done  <= v_d1;
    end
  end

  // input capture and coordinate differences
  always_ff @(posedge clk) begin
    rdeg[0] <= 30'(lat_b) - 30'(lat_a);
    rdeg[1] <= 30'(lon_b) - 30'(lon_a);
    rdeg[2] <= 30'(lat_a);
    rdeg[3] <= 30'(lat_b);
  end

  for (genvar k = 0; k < 4; k++) begin : g_ang
    gcd_rad u_rad (
      .clk   (clk),
      .halve (k < 2),
      .deg   (rdeg[k]),
      .z     (rz[k]),
      .flip  (rf[k])
    );
    assign rot[k][0] = '{valid: v_rad[G2R_LAT-1], tag: rf[k],
                         x: cw_t'(GAIN_Q30), y: '0, z: rz[k]};
    for (genvar i = 0; i < CE; i++) begin : g_rot
      gcd_cordic_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .mode (CORD_ROT),
        .idx  (5'(i)),
        .din  (rot[k][i]),
        .dout (rot[k][i+1])
      );
    end
  end

  always_comb begin
    sum = 33'(sl2_d) + 33'(t2);
    rnd = 28'((prod + (49'd1 << 20)) >> 21);
  end

  // haversine sum
  always_ff @(posedge clk) begin
    s_lat <= sel_q30(rot[0][CE].y, rot[0][CE].tag);
    s_lon <= sel_q30(rot[1][CE].y, rot[1][CE].tag);
    c_a   <= sel_q30(rot[2][CE].x, rot[2][CE].tag);
    c_b   <= sel_q30(rot[3][CE].x, rot[3][CE].tag);
    sl2   <= mul_q30(s_lat, s_lat);
    so2   <= mul_q30(s_lon, s_lon);
    cab   <= mul_q30(c_a, c_b);
    t2    <= mul_q30(so2, cab);
    sl2_d <= sl2;
    if (sum < 0) a3 <= '0;
    else if (sum > 33'(ONE_Q30)) a3 <= ONE_Q30;
    else a3 <= 31'(sum);
  end

  assign sq_c[0] = '{valid: v_m3, n: {a3, 30'b0}, r: '0};
  assign cq_c[0] = '{valid: v_m3, n: {ONE_Q30 - a3, 30'b0}, r: '0};

  for (genvar j = 0; j < SE; j++) begin : g_sqrt
    gcd_sqrt_cell u_sq (
      .clk  (clk),
      .rst  (rst),
      .idx  (5'(j)),
      .din  (sq_c[j]),
      .dout (sq_c[j+1])
    );
    gcd_sqrt_cell u_cq (
      .clk  (clk),
      .rst  (rst),
      .idx  (5'(j)),
      .din  (cq_c[j]),
      .dout (cq_c[j+1])
    );
  end

  // arcsine as atan2(sqrt(a), sqrt(1 - a))
  assign vec[0] = '{valid: sq_c[SE].valid & cq_c[SE].valid, tag: 1'b0,
                    x: cw_t'({3'b000, cq_c[SE].r[30:0]}),
                    y: cw_t'({3'b000, sq_c[SE].r[30:0]}), z: '0};

  for (genvar i = 0; i < CE; i++) begin : g_vec
    gcd_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .mode (CORD_VEC),
      .idx  (5'(i)),
      .din  (vec[i]),
      .dout (vec[i+1])
    );
  end

  always_ff @(posedge clk) begin
    ang  <= (vec[CE].z < 0) ? '0 : 33'(vec[CE].z);
    prod <= radius * ang;
    distance <= (rnd > 28'(DIST_MAX)) ? DIST_MAX : 26'(rnd);
  end

  a_busy_once: assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("busy held past the cycle after reset");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    v_m3 |=> (sq_c[1].n <= {1'b1, 60'b0} || !sq_c[1].valid))
    else $error("square-root radicand above one");

  a_vec_quadrant: assert property (@(posedge clk) disable iff (rst)
    vec[0].valid |-> (vec[0].x >= 0 && vec[0].y >= 0))
    else $error("vectoring input outside first quadrant");

endmodule

@@ tb/great_circle_distance_tb.sv @@
// testbench for the haversine great-circle distance pipeline
`timescale 1ns / 1ps

module great_circle_distance_tb;
  import gcd_pkg::*;

  localparam int  LATENCY   = 94;
  localparam int  CYCLE_CAP = 200000;
  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;
  localparam longint DEG     = 1 << 20;

  class distance_board;
    longint unsigned pending[$];
    longint unsigned radius_km;
    int errors;
    int points_in;
    int distances_out;
    int saturated;

    function new();
      radius_km = RADIUS_RESET;
      errors = 0;
      points_in = 0;
      distances_out = 0;
      saturated = 0;
    endfunction

    function automatic longint rad_q30(longint deg, int halve);
      longint unsigned mag, prod;
      longint r;
      int sh;
      mag = (deg < 0) ? -deg : deg;
      sh = ANGLE_FRAC_BITS + 2 + halve;
      prod = (mag * 64'h3243F6A88) / 180;
      r = (prod + (64'd1 << (sh - 1))) >> sh;
      return (deg < 0) ? -r : r;
    endfunction

    function automatic void rotate(input longint ang, output longint s, output longint c);
      longint pi_q, two_pi, half_pi, a, x, y, z, dx, dy;
      longint unsigned mag;
      bit flip;
      pi_q = 64'h3243F6A88 >> 2;
      two_pi = 64'h3243F6A88 >> 1;
      half_pi = 64'h3243F6A88 >> 3;
      mag = (ang < 0) ? -ang : ang;
      a = mag % two_pi;
      flip = 0;
      if (a > pi_q) a -= two_pi;
      if (ang < 0) a = -a;
      // fold into the right half plane, flipping both signs
      if (a > half_pi) begin
        a -= pi_q;
        flip = 1;
      end else if (a < -half_pi) begin
        a += pi_q;
        flip = 1;
      end
      x = GAIN_Q30;
      y = 0;
      z = a;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i & 31]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i & 31]);
        end
      end
      if (x > (1 << 30)) x = 1 << 30;
      if (x < -(1 << 30)) x = -(1 << 30);
      if (y > (1 << 30)) y = 1 << 30;
      if (y < -(1 << 30)) y = -(1 << 30);
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function automatic longint mulq(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic longint central_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i & 31]);
        end else begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i & 31]);
        end
      end
      return (z < 0) ? 0 : z;
    endfunction

    function void note_points(longint la, longint oa, longint lb, longint ob);
      longint s_lat, s_lon, c_a, c_b, unused, hav, sq, cq, d;
      rotate(rad_q30(lb - la, 1), s_lat, unused);
      rotate(rad_q30(ob - oa, 1), s_lon, unused);
      rotate(rad_q30(la, 0), unused, c_a);
      rotate(rad_q30(lb, 0), unused, c_b);
      hav = mulq(s_lat, s_lat) + mulq(mulq(s_lon, s_lon), mulq(c_a, c_b));
      if (hav < 0) hav = 0;
      if (hav > (1 << 30)) hav = 1 << 30;
      sq = root(longint'(hav) << 30);
      cq = root(longint'((1 << 30) - hav) << 30);
      d = (longint'(radius_km) * 2 * central_angle(sq, cq) + (1 << 21)) >> 22;
      if (d > longint'(DIST_MAX)) begin
        d = DIST_MAX;
        saturated++;
      end
      pending.insert(pending.size(), d);
      points_in++;
    endfunction

    function void check_distance(logic [25:0] got);
      longint unsigned want;
      distances_out++;
      if (pending.size() == 0) begin
        $error("distance: no transfer pending, actual %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want[25:0]) begin
        $error("distance: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [27:0] lat_a;
  logic signed [28:0] lon_a;
  logic signed [27:0] lat_b;
  logic signed [28:0] lon_b;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;
  logic               done;
  logic [25:0]        distance;

  distance_board board;
  int cycles;
  bit no_idle;

  great_circle_distance dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .distance(distance)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("great_circle_distance_tb: done, errors");
      $finish;
    end
  end

  // monitors sample the values that the edge itself sees
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) board.radius_km = cfg_wdata;
      if (start && !busy)
        board.note_points(longint'(lat_a), longint'(lon_a), longint'(lat_b), longint'(lon_b));
      if (done) board.check_distance(distance);
    end
  end

  task automatic send(longint la, longint oa, longint lb, longint ob);
    start <= 1'b1;
    lat_a <= la[27:0];
    lon_a <= oa[28:0];
    lat_b <= lb[27:0];
    lon_b <= ob[28:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY / 4) @(posedge clk);
  endtask

  task automatic set_radius(logic [15:0] r);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic longint pick(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic random_point_pair();
    longint la, oa, lb, ob;
    int kind;
    kind = $urandom_range(0, 99);
    la = pick(LAT_MAX);
    oa = pick(LON_MAX);
    if (kind < 15) begin
      // close points, short distances
      lb = la + pick(DEG);
      ob = oa + pick(DEG);
    end else if (kind < 22) begin
      // full field width, beyond the poles and the date line
      la = longint'($signed($urandom() & 32'h0FFFFFFF) <<< 4) >>> 4;
      oa = longint'($signed($urandom() & 32'h1FFFFFFF) <<< 3) >>> 3;
      lb = longint'($signed($urandom() & 32'h0FFFFFFF) <<< 4) >>> 4;
      ob = longint'($signed($urandom() & 32'h1FFFFFFF) <<< 3) >>> 3;
    end else begin
      lb = pick(LAT_MAX);
      ob = pick(LON_MAX);
    end
    if (kind >= 15 && kind < 22) begin
      la = longint'($signed(la[27:0]));
      lb = longint'($signed(lb[27:0]));
    end
    send(la, oa, lb, ob);
    if (!no_idle && $urandom_range(0, 99) < 23) pause($urandom_range(1, 6));
  endtask

  initial begin
    logic [15:0] radii [5];
    board = new();
    cycles = 0;
    no_idle = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    lat_a = '0; lon_a = '0; lat_b = '0; lon_b = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, same point, antipodes, poles, range and field extremes
    send(0, 0, 0, 0);
    send(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
    send(0, 0, 0, 180 * DEG);
    send(0, -LON_MAX, 0, LON_MAX);
    send(90 * DEG, 0, -90 * DEG, 0);
    send(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
    send(-LAT_MAX, 0, LAT_MAX, 17 * DEG);
    send(45 * DEG, 90 * DEG, -45 * DEG, -90 * DEG);
    send(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1);
    send((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28));
    pause(3);
    send(1, 1, -1, -1);
    send(10 * DEG, 20 * DEG, 10 * DEG + 1, 20 * DEG);
    send(0, 0, 270 * DEG, 0);

    set_radius(16'd65535);
    send(0, 0, 0, 180 * DEG);
    send(90 * DEG, 0, -90 * DEG, 0);
    send(0, 0, 0, 90 * DEG);
    set_radius(16'd0);
    send(0, 0, 0, 180 * DEG);
    send(12 * DEG, 3 * DEG, -40 * DEG, 100 * DEG);
    set_radius(16'd1);
    send(0, 0, 0, 180 * DEG);

    radii[0] = RADIUS_RESET;
    radii[1] = 16'd65535;
    radii[2] = 16'd1;
    radii[3] = 16'($urandom_range(2, 65534));
    radii[4] = 16'($urandom_range(2, 65534));
    for (int p = 0; p < 5; p++) begin
      set_radius(radii[p]);
      for (int k = 0; k < 240; k++) begin
        no_idle = (p == 1 && k < 200);
        if (p == 3 && k == 120) drain();
        random_point_pair();
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d point pairs, %0d distances, %0d saturated, radius down to 0",
             board.points_in, board.distances_out, board.saturated);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("great_circle_distance_tb: done, clean");
    end else begin
      $display("great_circle_distance_tb: done, errors");
    end
    $finish;
  end

endmodule
